>>> rtl/ifmt_pkg.sv
// Package for the integer to ASCII formatter.
// Holds the transfer payload types, character and radix codes and the digit helpers.
// No dependencies.
package ifmt_pkg;

  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_A_UPPER = 8'h41;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_X_LOWER = 8'h78;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        negative;
    logic [1:0]  radix_sel;
    logic        upper_case;
    logic        left_justify;
    logic [6:0]  field_width;
    logic        zero_fill;
    logic        has_precision;
    logic [5:0]  precision;
    logic        alternate;
    logic        blank_sign;
    logic        plus_sign;
  } ifmt_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_empty;
    logic       last;
  } ifmt_out_t;

  // Control from the sequencer to the digit chain.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [1:0] radix_sel;
  } ifmt_dig_ctrl_t;

  // Decimal digits of five or more get three added before each shift.
  function automatic logic [3:0] digit_adjust(logic [3:0] s, logic dec);
    digit_adjust = (dec && (s >= 4'd5)) ? s + 4'd3 : s;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic up);
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0000, d};
    end else begin
      digit_char = (up ? CH_A_UPPER : CH_A_LOWER) + {4'b0000, d} - 8'd10;
    end
  endfunction

endpackage

>>> rtl/ifmt_digits.sv
// Bit-serial radix converter: shifts the value in one bit a cycle on step through a chain
// of 4-bit digit slots (shift-and-add-3 for decimal, plain 3- or 4-bit groups otherwise).
// Depends on ifmt_pkg.
module ifmt_digits
  import ifmt_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ifmt_dig_ctrl_t                      ctrl_i,
  input  logic [VALUE_BITS-1:0]               magnitude_i,
  input  logic [$clog2((VALUE_BITS+2)/3)-1:0] rd_idx_i,
  output logic [$clog2((VALUE_BITS+2)/3+1)-1:0] nd_o,
  output logic [3:0]                          digit_o
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int IDXW = $clog2(NDIG);
  localparam int NDW  = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] val_q;
  logic [3:0]            slot_q [NDIG];
  logic [3:0]            slot_d [NDIG];
  logic [3:0]            adj    [NDIG];
  logic [NDIG-1:0]       carry;
  logic [NDIG-1:0]       cin;
  logic [NDW-1:0]        nd_q, nd_d, nd_m1;
  logic [1:0]            radix_q;
  logic                  is_oct, is_dec;
  logic [IDXW-1:0]       sel_idx;
  logic [3:0]            sel_slot, sel_adj;
  logic                  top_carry;

  assign is_oct = (radix_q == RADIX_OCT);
  assign is_dec = (radix_q == RADIX_DEC);

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[k]   = digit_adjust(slot_q[k], is_dec);
      carry[k] = is_oct ? adj[k][2] : adj[k][3];
    end
  end

  assign cin = {carry[NDIG-2:0], val_q[VALUE_BITS-1]};

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      slot_d[k] = is_oct ? {1'b0, adj[k][1:0], cin[k]} : {adj[k][2:0], cin[k]};
    end
  end

  // One read port: the top occupied slot while converting, the emitter's digit afterwards.
  assign nd_m1    = nd_q - 1'b1;
  assign sel_idx  = ctrl_i.step ? nd_m1[IDXW-1:0] : rd_idx_i;
  assign sel_slot = slot_q[sel_idx];
  assign sel_adj  = digit_adjust(sel_slot, is_dec);
  assign top_carry = is_oct ? sel_adj[2] : sel_adj[3];

  // Digit count: one on the first set bit, plus one per spill from the top occupied slot.
  always_comb begin
    nd_d = nd_q;
    if (nd_q == '0) begin
      nd_d = val_q[VALUE_BITS-1] ? NDW'(1) : '0;
    end else if (top_carry) begin
      nd_d = nd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= '0;
    end else if (ctrl_i.load) begin
      nd_q <= '0;
    end else if (ctrl_i.step) begin
      nd_q <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      val_q   <= magnitude_i;
      radix_q <= ctrl_i.radix_sel;
      for (int k = 0; k < NDIG; k++) begin
        slot_q[k] <= 4'd0;
      end
    end else if (ctrl_i.step) begin
      val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
      for (int k = 0; k < NDIG; k++) begin
        slot_q[k] <= slot_d[k];
      end
    end
  end

  assign nd_o    = nd_q;
  assign digit_o = sel_slot;

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: one printf-style integer conversion per input transfer.
// Depends on ifmt_pkg and ifmt_digits.
//
// A request is taken only when the block is idle. The magnitude is shifted one bit a
// cycle through the digit chain, followed by a setup state that sizes the padding,
// prefix and zero runs. The characters then leave at one per cycle while the output is
// not stalled, with no character sent while the emitter moves across each of the five
// segment boundaries. An empty conversion gives a single result with is_empty and last
// set. There is no clearing pass after reset.
module integer_to_ascii_formatter
  import ifmt_pkg::*;
#(
  parameter int VALUE_BITS    = 64,
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_PRECISION = 60
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ifmt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ifmt_out_t out_data_o
);

  localparam int NDIG = (VALUE_BITS + 2) / 3;
  localparam int IDXW = $clog2(NDIG);
  localparam int NDW  = $clog2(NDIG + 1);
  localparam int BCW  = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_SETUP = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    SEG_LPAD   = 3'd0,
    SEG_PREFIX = 3'd1,
    SEG_ZEROS  = 3'd2,
    SEG_DIGITS = 3'd3,
    SEG_RPAD   = 3'd4,
    SEG_DONE   = 3'd5
  } seg_e;

  state_e         state_q, state_d;
  seg_e           seg_q, seg_d, seg_next;
  logic [6:0]     rem_q, rem_d, len_next;
  logic [6:0]     emit_cnt_q, emit_cnt_d;
  logic [BCW-1:0] bit_cnt_q, bit_cnt_d;
  ifmt_in_t       req_q, req_d;
  logic [23:0]    pre_q, pre_d;
  logic [1:0]     np_q, np_d;
  logic [6:0]     zeros_q, zeros_d, rpad_q, rpad_d, out_len_q, out_len_d;
  logic [NDW-1:0] nd_eff_q, nd_eff_d;
  logic           out_valid_q, out_valid_d;
  ifmt_out_t      out_q, out_d;
  logic           out_free;

  ifmt_dig_ctrl_t dig_ctrl;
  logic [NDW-1:0] nd_raw;
  logic [3:0]     digit;
  logic [6:0]     dig_pos;

  // Setup arithmetic
  logic           is_oct, is_dec, is_hex, zpad;
  logic [NDW-1:0] nd_eff;
  logic [6:0]     nzeros, total, pad;
  logic [1:0]     np;
  logic [23:0]    pre_raw, pre_aln;
  logic [7:0]     emit_char;

  assign dig_pos = rem_q - 7'd1;

  ifmt_digits #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digits (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dig_ctrl),
    .magnitude_i(in_data_i.magnitude[VALUE_BITS-1:0]),
    .rd_idx_i   (dig_pos[IDXW-1:0]),
    .nd_o       (nd_raw),
    .digit_o    (digit)
  );

  always_comb begin
    is_oct = (req_q.radix_sel == RADIX_OCT);
    is_dec = (req_q.radix_sel == RADIX_DEC);
    is_hex = !is_oct && !is_dec;

    // A zero value prints one digit unless an explicit precision of zero was given.
    if (nd_raw == '0) begin
      nd_eff = (req_q.has_precision && (req_q.precision == '0)) ? '0 : NDW'(1);
    end else begin
      nd_eff = nd_raw;
    end

    if (req_q.has_precision && ({1'b0, req_q.precision} > 7'(nd_eff))) begin
      nzeros = {1'b0, req_q.precision} - 7'(nd_eff);
    end else begin
      nzeros = 7'd0;
    end

    pre_raw = '0;
    np      = 2'd0;
    if (req_q.negative) begin
      pre_raw = {pre_raw[15:0], CH_MINUS};
      np      = np + 2'd1;
    end else if (req_q.plus_sign) begin
      pre_raw = {pre_raw[15:0], CH_PLUS};
      np      = np + 2'd1;
    end else if (req_q.blank_sign) begin
      pre_raw = {pre_raw[15:0], CH_SPACE};
      np      = np + 2'd1;
    end
    if (req_q.alternate && is_hex && (nd_raw != '0)) begin
      pre_raw = {pre_raw[7:0], CH_ZERO, (req_q.upper_case ? CH_X_UPPER : CH_X_LOWER)};
      np      = np + 2'd2;
    end
    // The octal marker is dropped when the printed digits already begin with a zero.
    if (req_q.alternate && is_oct && (nzeros == '0) && ((nd_raw != '0) || (nd_eff == '0)))
    begin
      pre_raw = {pre_raw[15:0], CH_ZERO};
      np      = np + 2'd1;
    end

    case (np)
      2'd0:    pre_aln = '0;
      2'd1:    pre_aln = {pre_raw[7:0], 16'h0000};
      2'd2:    pre_aln = {pre_raw[15:0], 8'h00};
      default: pre_aln = pre_raw;
    endcase

    total = 7'(np) + nzeros + 7'(nd_eff);
    pad   = (req_q.field_width > total) ? req_q.field_width - total : 7'd0;
    zpad  = req_q.zero_fill && !req_q.left_justify && !req_q.has_precision;
  end

  always_comb begin
    case (seg_q)
      SEG_LPAD: begin
        seg_next = SEG_PREFIX;
        len_next = {5'd0, np_q};
      end
      SEG_PREFIX: begin
        seg_next = SEG_ZEROS;
        len_next = zeros_q;
      end
      SEG_ZEROS: begin
        seg_next = SEG_DIGITS;
        len_next = 7'(nd_eff_q);
      end
      SEG_DIGITS: begin
        seg_next = SEG_RPAD;
        len_next = rpad_q;
      end
      default: begin
        seg_next = SEG_DONE;
        len_next = 7'd0;
      end
    endcase
  end

  always_comb begin
    case (seg_q)
      SEG_LPAD, SEG_RPAD: emit_char = CH_SPACE;
      SEG_PREFIX:         emit_char = pre_q[23:16];
      SEG_ZEROS:          emit_char = CH_ZERO;
      SEG_DIGITS:         emit_char = digit_char(digit, req_q.upper_case);
      default:            emit_char = CH_NUL;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    rem_d       = rem_q;
    emit_cnt_d  = emit_cnt_q;
    bit_cnt_d   = bit_cnt_q;
    req_d       = req_q;
    pre_d       = pre_q;
    np_d        = np_q;
    zeros_d     = zeros_q;
    rpad_d      = rpad_q;
    out_len_d   = out_len_q;
    nd_eff_d    = nd_eff_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    dig_ctrl    = '{load: 1'b0, step: 1'b0, radix_sel: in_data_i.radix_sel};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dig_ctrl.load = 1'b1;
          req_d         = in_data_i;
          if (in_data_i.field_width > 7'(MAX_WIDTH)) begin
            req_d.field_width = 7'(MAX_WIDTH);
          end
          if (in_data_i.precision > 6'(MAX_PRECISION)) begin
            req_d.precision = 6'(MAX_PRECISION);
          end
          bit_cnt_d = BCW'(VALUE_BITS - 1);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        dig_ctrl.step = 1'b1;
        bit_cnt_d     = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pre_d      = pre_aln;
        np_d       = np;
        nd_eff_d   = nd_eff;
        zeros_d    = nzeros + ((!req_q.left_justify && zpad) ? pad : 7'd0);
        rpad_d     = req_q.left_justify ? pad : 7'd0;
        out_len_d  = pad + total;
        emit_cnt_d = 7'd0;
        seg_d      = SEG_LPAD;
        rem_d      = (!req_q.left_justify && !zpad) ? pad : 7'd0;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_len_q == '0) begin
          if (out_free) begin
            out_valid_d    = 1'b1;
            out_d.out_char = CH_NUL;
            out_d.is_empty = 1'b1;
            out_d.last     = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (seg_q == SEG_DONE) begin
          state_d = ST_IDLE;
        end else if (rem_q == '0) begin
          seg_d = seg_next;
          rem_d = len_next;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.out_char = emit_char;
          out_d.is_empty = 1'b0;
          out_d.last     = (emit_cnt_q == out_len_q - 7'd1);
          rem_d          = rem_q - 7'd1;
          emit_cnt_d     = emit_cnt_q + 7'd1;
          if (seg_q == SEG_PREFIX) begin
            pre_d = {pre_q[15:0], 8'h00};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= SEG_DONE;
      rem_q       <= 7'd0;
      emit_cnt_q  <= 7'd0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      rem_q       <= rem_d;
      emit_cnt_q  <= emit_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    pre_q     <= pre_d;
    np_q      <= np_d;
    zeros_q   <= zeros_d;
    rpad_q    <= rpad_d;
    out_len_q <= out_len_d;
    nd_eff_q  <= nd_eff_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // An empty conversion is always the one and only result of its request.
  a_empty_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_empty) |-> out_q.last)
    else $error("empty result not marked last");

  // The emitter never sends more characters than the sized field.
  a_emit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (emit_cnt_q <= out_len_q))
    else $error("character count beyond field length");

  // Digit reads stay within the effective digit count.
  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && seg_q == SEG_DIGITS) |-> (rem_q <= 7'(nd_eff_q)))
    else $error("digit index beyond digit count");

  // An accepted request goes straight into conversion.
  a_accept_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CONV))
    else $error("accepted request did not start conversion");
`endif

endmodule
